// File: rtl/spc_pkg.sv
// ---------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the stereo peak compressor.
// ---------------------------------------------------------------------------
package spc_pkg;

   localparam int CHANNELS = 2;
   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 24;
   localparam int ENV_W    = 25;
   localparam int GAIN_W   = 16;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_STEPS = 15;
   localparam int DIV_CNT_W = 4;

   localparam logic [ENV_W-1:0] ENV_ONE = 25'h1000000;
   localparam logic [ENV_W-1:0] ENV_EPS = 25'd168;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;

   localparam logic [COEF_W-1:0] THRESHOLD_RST = 24'd4697620;
   localparam logic [COEF_W-1:0] INV_RATIO_RST = 24'd11983726;
   localparam logic [COEF_W-1:0] ATTACK_RST    = 24'd16733579;
   localparam logic [COEF_W-1:0] RELEASE_RST   = 24'd16774303;
   localparam logic [GAIN_W-1:0] MAKEUP_RST    = 16'd32768;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_RATIO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAKEUP    = 3'd5;

   typedef struct packed {
      logic [COEF_W-1:0] threshold;
      logic [COEF_W-1:0] inverse_ratio;
      logic [COEF_W-1:0] attack_coeff;
      logic [COEF_W-1:0] release_coeff;
      logic [GAIN_W-1:0] makeup_gain;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ENV, ST_NUM, ST_DIV, ST_MUL, ST_OUT, ST_HOLD
   } lane_state_type;

endpackage

// File: rtl/spc_lane.sv
// ---------------------------------------------------------------------------
// spc_lane
// One channel: envelope follower, serial gain divider, gain and saturation.
// ---------------------------------------------------------------------------
module spc_lane
   import spc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       ack,
   input  cfg_type                    cfg,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic                       done,
   output logic signed [SAMPLE_W-1:0] result,
   output logic                       clip
);

   lane_state_type state_ff, state_in;
   logic [ENV_W-1:0]     env_ff, env_in;
   logic [SAMPLE_W-1:0]  absx_ff, absx_in;
   logic                 neg_ff, neg_in;
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [ENV_W+1:0]     rem_ff, rem_in;
   logic [ENV_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [39:0]          pa_ff, pa_in;
   logic signed [SAMPLE_W-1:0] res_ff, res_in;
   logic                 clip_ff, clip_in;

   logic [ENV_W-1:0] mag;
   logic [COEF_W:0]  coef, coef_c;
   logic [50:0]      env_sum;
   logic [48:0]      excess_mul;
   logic [ENV_W-1:0] num;
   logic [ENV_W+1:0] rem_sh;
   logic [55:0]      prod;
   logic [32:0]      rnd;

   always_comb begin
      state_in = state_ff;
      env_in   = env_ff;
      absx_in  = absx_ff;
      neg_in   = neg_ff;
      gain_in  = gain_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      pa_in    = pa_ff;
      res_in   = res_ff;
      clip_in  = clip_ff;
      mag      = {absx_ff, 1'b0};
      coef     = (mag > env_ff) ? {1'b0, cfg.attack_coeff} : {1'b0, cfg.release_coeff};
      coef_c   = ENV_ONE - coef;
      env_sum  = 51'(coef) * 51'(env_ff) + 51'(coef_c) * 51'(mag) + 51'(24'h800000);
      excess_mul = 49'(env_ff - ENV_W'(cfg.threshold)) * 49'(cfg.inverse_ratio);
      num      = ENV_W'(cfg.threshold) + ENV_W'(excess_mul[48:24]);
      rem_sh   = {rem_ff[ENV_W:0], 1'b0};
      prod     = 56'(pa_ff) * 56'(cfg.makeup_gain);
      rnd      = 33'((prod + 56'(1 << 29)) >> 30);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = sample[SAMPLE_W-1];
               absx_in  = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
               state_in = ST_ENV;
            end
         end
         // envelope update
         ST_ENV: begin
            env_in   = env_sum[48:24];
            state_in = ST_NUM;
         end
         // numerator and divider setup, numerator is below the divisor
         ST_NUM: begin
            den_in  = env_ff + ENV_EPS;
            rem_in  = {2'b00, num};
            gain_in = '0;
            cnt_in  = '0;
            state_in = (env_ff > ENV_W'(cfg.threshold)) ? ST_DIV : ST_MUL;
            if (env_ff <= ENV_W'(cfg.threshold)) gain_in = GAIN_UNITY;
         end
         // restoring divide of num<<15, one quotient bit a cycle
         ST_DIV: begin
            if (rem_sh >= {2'b00, den_ff}) begin
               rem_in  = rem_sh - {2'b00, den_ff};
               gain_in = {gain_ff[GAIN_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               gain_in = {gain_ff[GAIN_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = ST_MUL;
         end
         // sample times gain
         ST_MUL: begin
            pa_in    = 40'(absx_ff) * 40'(gain_ff);
            state_in = ST_OUT;
         end
         // makeup, rounding, saturation
         ST_OUT: begin
            clip_in = 1'b0;
            if (neg_ff) begin
               if (rnd > 33'd8388608) begin
                  res_in  = -SAMPLE_W'(8388608);
                  clip_in = 1'b1;
               end else begin
                  res_in = SAMPLE_W'(-rnd);
               end
            end else if (rnd > 33'd8388607) begin
               res_in  = SAMPLE_W'(8388607);
               clip_in = 1'b1;
            end else begin
               res_in = SAMPLE_W'(rnd);
            end
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (ack) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         env_ff   <= '0;
      end else begin
         state_ff <= state_in;
         env_ff   <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      absx_ff <= absx_in;
      neg_ff  <= neg_in;
      gain_ff <= gain_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      pa_ff   <= pa_in;
      res_ff  <= res_in;
      clip_ff <= clip_in;
   end

   assign done   = (state_ff == ST_HOLD);
   assign result = res_ff;
   assign clip   = clip_ff;

endmodule

// File: rtl/stereo_peak_compressor_unit.sv
// bypassed frames go straight to the result register; at or below threshold the lanes
// step through envelope, numerator, multiply and output, and above it the gain divider
// runs after the numerator (15 quotient bits, one a cycle); a new frame is taken in
// the cycle after the last is handed to the result register; a full one stalls the lanes
// reset: synchronous, clears envelopes and loads register defaults
// ---------------------------------------------------------------------------
// stereo_peak_compressor_unit
// Top level: configuration registers, channel lanes and output merge.
// ---------------------------------------------------------------------------
module stereo_peak_compressor_unit
   import spc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   output logic                       rsp_clipped,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_data
);

   logic    enable_ff;
   cfg_type cfg_ff;
   logic    busy_ff, busy_in;
   logic    byp_ff, byp_in;
   logic signed [SAMPLE_W-1:0] s_ff [2];
   logic signed [SAMPLE_W-1:0] o_ff [2];
   logic    clip_ff;
   logic    out_ff, out_in;
   logic    [CHANNELS-1:0] lane_done, lane_clip;
   logic signed [SAMPLE_W-1:0] lane_res [CHANNELS];
   logic    acc, lanes_ok, start, fin;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         cfg_ff    <= '{THRESHOLD_RST, INV_RATIO_RST, ATTACK_RST, RELEASE_RST, MAKEUP_RST};
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ENABLE:    enable_ff <= csr_data[0];
            REG_THRESHOLD: cfg_ff.threshold <= csr_data;
            REG_INV_RATIO: cfg_ff.inverse_ratio <= csr_data;
            REG_ATTACK:    cfg_ff.attack_coeff <= csr_data;
            REG_RELEASE:   cfg_ff.release_coeff <= csr_data;
            REG_MAKEUP:    cfg_ff.makeup_gain <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign acc       = req_valid && req_ready;
   assign start     = acc && enable_ff;
   assign lanes_ok  = byp_ff || (&lane_done);
   // frame leaves the lanes once the result register is free or being read
   assign fin       = busy_ff && lanes_ok && (!out_ff || rsp_ready);

   // lanes
   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      spc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .start  (start),
         .ack    (fin),
         .cfg    (cfg_ff),
         .sample ((g == 0) ? req_left_in : req_right_in),
         .done   (lane_done[g]),
         .result (lane_res[g]),
         .clip   (lane_clip[g])
      );
   end

   // frame control
   always_comb begin
      busy_in = busy_ff;
      byp_in  = byp_ff;
      out_in  = out_ff;
      if (out_ff && rsp_ready) begin
         out_in = 1'b0;
      end
      if (acc) begin
         busy_in = 1'b1;
         byp_in  = !enable_ff;
      end
      if (fin) begin
         busy_in = 1'b0;
         out_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         byp_ff  <= 1'b0;
         out_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         byp_ff  <= byp_in;
         out_ff  <= out_in;
      end
   end

   // merge lane results into the output beat
   always_ff @(posedge clock) begin
      if (acc) begin
         s_ff[0] <= req_left_in;
         s_ff[1] <= req_right_in;
      end
      if (fin) begin
         for (int i = 0; i < 2; i++) begin
            o_ff[i] <= (!byp_ff && i < CHANNELS) ? lane_res[i] : s_ff[i];
         end
         clip_ff <= !byp_ff && (|lane_clip);
      end
   end

   assign rsp_valid     = out_ff;
   assign rsp_left_out  = o_ff[0];
   assign rsp_right_out = o_ff[1];
   assign rsp_clipped   = clip_ff;

endmodule
